// ===== hw/rtl/rrqs_pkg.sv =====
`timescale 1ns / 1ps
package rrqs_pkg;
	localparam int MaxTasks = 16;
	localparam int IdxW = 4;
	localparam int CntW = 5;
	localparam int TimeW = 16;
	localparam int QuantW = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [0:0] REG_QUANTUM = 1'b0;
	localparam logic [0:0] REG_TASK_COUNT = 1'b1;

	// input request, packed from tdata and tuser
	typedef struct packed {
		logic [TimeW-1:0] burst_time;
		logic [TimeW-1:0] arrival_time;
		logic [IdxW-1:0] task_index;
		logic operation;
	} in_req_t;

	// result fields
	typedef struct packed {
		logic all_done;
		logic [TimeW-1:0] response_time;
		logic [TimeW-1:0] waiting_time;
		logic [TimeW-1:0] turnaround_time;
		logic [TimeW-1:0] completion_time;
		logic [IdxW-1:0] finished_task;
		logic finished_valid;
		logic preempted;
		logic dispatched;
		logic [TimeW-1:0] remaining_burst;
		logic [IdxW-1:0] running_task;
		logic running_valid;
	} out_res_t;

	// controller commands
	typedef struct packed {
		logic do_load;
		logic tick_start;
		logic scan_step;
		logic preempt_step;
		logic disp_step;
		logic finish_item;
	} cmd_t;

	// datapath status
	typedef struct packed {
		logic scan_last;
		logic need_preempt;
		logic disp_done;
	} sts_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TICK = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_PRE = 6'b001000,
		ST_DISP = 6'b010000,
		ST_OUT = 6'b100000
	} state_t;
endpackage

// ===== hw/rtl/rrqs_ctrl.sv =====
`timescale 1ns / 1ps
module rrqs_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic in_is_tick,
	input logic out_free,
	input rrqs_pkg::sts_t sts,
	output rrqs_pkg::cmd_t cmd,
	output logic busy
);
	import rrqs_pkg::*;

	state_t state_q, state_d;

	// sequencing of one request
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_is_tick) begin
						cmd.tick_start = 1'b1;
						state_d = ST_SCAN;
					end else begin
						cmd.do_load = 1'b1;
						state_d = ST_OUT;
					end
				end
			end
			ST_TICK: state_d = ST_SCAN;
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = ST_PRE;
			end
			ST_PRE: begin
				cmd.preempt_step = 1'b1;
				state_d = ST_DISP;
			end
			ST_DISP: begin
				cmd.disp_step = 1'b1;
				if (sts.disp_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.finish_item = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ===== hw/rtl/rrqs_datapath.sv =====
`timescale 1ns / 1ps
module rrqs_datapath (
	input logic clk,
	input logic arst_n,
	input rrqs_pkg::in_req_t req,
	input rrqs_pkg::cmd_t cmd,
	input logic cfg_we,
	input logic [0:0] cfg_sel,
	input logic [rrqs_pkg::QuantW-1:0] cfg_data,
	output rrqs_pkg::sts_t sts,
	output rrqs_pkg::out_res_t res
);
	import rrqs_pkg::*;

	logic [TimeW-1:0] arr_q [MaxTasks];
	logic [TimeW-1:0] bur_q [MaxTasks];
	logic [TimeW-1:0] rem_q [MaxTasks];
	logic [TimeW-1:0] rsp_q [MaxTasks];
	logic [MaxTasks-1:0] started_q, queued_q, nz_q;
	logic [IdxW-1:0] fifo_q [MaxTasks];
	logic [IdxW-1:0] head_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] cur_q;
	logic cur_valid_q;
	logic [QuantW-1:0] slice_q;
	logic [TimeW-1:0] now_q;
	logic [QuantW-1:0] quantum_q;
	logic [CntW-1:0] tcount_q;
	logic [IdxW-1:0] scan_q;
	logic disp_q, pre_q;
	logic fin_q;
	logic [IdxW-1:0] fin_task_q;
	logic [TimeW-1:0] ct_q, tat_q, wt_q, rt_q;

	logic [CntW-1:0] n_act;
	logic [TimeW-1:0] now_inc, cur_rem, rem_dec, tat_c;
	logic [IdxW-1:0] tail, head_t;
	logic scan_ok, head_ok;
	logic [MaxTasks-1:0] act_mask;

	assign n_act = (tcount_q > CntW'(MaxTasks)) ? CntW'(MaxTasks) : tcount_q;
	assign now_inc = now_q + 1'b1;
	assign cur_rem = rem_q[cur_q];
	assign rem_dec = (cur_rem != '0) ? cur_rem - 1'b1 : cur_rem;
	assign tat_c = now_inc - arr_q[cur_q];
	assign tail = head_q + count_q[IdxW-1:0];
	assign head_t = fifo_q[head_q];
	assign scan_ok = ({1'b0, scan_q} < n_act) && !queued_q[scan_q]
		&& (arr_q[scan_q] <= now_q) && (rem_q[scan_q] != '0);
	assign head_ok = ({1'b0, head_t} < n_act) && (rem_q[head_t] != '0);

	assign sts.scan_last = (scan_q == IdxW'(MaxTasks - 1));
	assign sts.need_preempt = cur_valid_q && (slice_q == '0);
	assign sts.disp_done = cur_valid_q || (count_q == '0) || head_ok;

	always_comb begin
		for (int i = 0; i < MaxTasks; i++) act_mask[i] = (i < n_act);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QuantW'(1);
			tcount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_sel)
				REG_QUANTUM: quantum_q <= cfg_data;
				REG_TASK_COUNT: tcount_q <= cfg_data[CntW-1:0];
				default: ;
			endcase
		end
	end

	// tables without reset
	always_ff @(posedge clk) begin
		if (cmd.do_load) begin
			arr_q[req.task_index] <= req.arrival_time;
			bur_q[req.task_index] <= req.burst_time;
			rem_q[req.task_index] <= req.burst_time;
		end else if (cmd.tick_start && cur_valid_q) begin
			rem_q[cur_q] <= rem_dec;
		end
		if (cmd.scan_step && scan_ok && count_q != CntW'(MaxTasks))
			fifo_q[tail] <= scan_q;
		if (cmd.preempt_step && sts.need_preempt && count_q != CntW'(MaxTasks))
			fifo_q[tail] <= cur_q;
		if (cmd.disp_step && !cur_valid_q && count_q != '0 && head_ok
			&& !started_q[head_t])
			rsp_q[head_t] <= now_q - arr_q[head_t];
		if (cmd.tick_start) begin
			ct_q <= now_inc;
			tat_q <= tat_c;
			wt_q <= tat_c - bur_q[cur_q];
			rt_q <= rsp_q[cur_q];
			fin_task_q <= cur_q;
		end
	end

	// scheduler control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
			queued_q <= '0;
			nz_q <= '0;
			head_q <= '0;
			count_q <= '0;
			cur_q <= '0;
			cur_valid_q <= 1'b0;
			slice_q <= '0;
			now_q <= '0;
			scan_q <= '0;
			disp_q <= 1'b0;
			pre_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			if (cmd.do_load) begin
				started_q[req.task_index] <= 1'b0;
				queued_q[req.task_index] <= 1'b0;
				nz_q[req.task_index] <= (req.burst_time != '0);
				disp_q <= 1'b0;
				pre_q <= 1'b0;
				fin_q <= 1'b0;
			end
			if (cmd.tick_start) begin
				now_q <= now_inc;
				scan_q <= '0;
				disp_q <= 1'b0;
				pre_q <= 1'b0;
				fin_q <= cur_valid_q && (rem_dec == '0);
				if (cur_valid_q) begin
					if (slice_q != '0) slice_q <= slice_q - 1'b1;
					nz_q[cur_q] <= (rem_dec != '0);
					if (rem_dec == '0) cur_valid_q <= 1'b0;
				end
			end
			if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
				if (scan_ok) begin
					queued_q[scan_q] <= 1'b1;
					if (count_q != CntW'(MaxTasks)) count_q <= count_q + 1'b1;
				end
			end
			if (cmd.preempt_step && sts.need_preempt) begin
				pre_q <= 1'b1;
				cur_valid_q <= 1'b0;
				if (count_q != CntW'(MaxTasks)) count_q <= count_q + 1'b1;
			end
			// pop one head entry per cycle while dispatching with no running task and a non-empty queue
			if (cmd.disp_step && !cur_valid_q && count_q != '0) begin
				head_q <= head_q + 1'b1;
				count_q <= count_q - 1'b1;
				if (head_ok) begin
					cur_q <= head_t;
					cur_valid_q <= 1'b1;
					slice_q <= (quantum_q == '0) ? QuantW'(1) : quantum_q;
					disp_q <= 1'b1;
					started_q[head_t] <= 1'b1;
				end
			end
		end
	end

	// result assembly
	always_comb begin
		res.running_valid = cur_valid_q;
		res.running_task = cur_valid_q ? cur_q : '0;
		res.remaining_burst = cur_valid_q ? cur_rem : '0;
		res.dispatched = disp_q;
		res.preempted = pre_q;
		res.finished_valid = fin_q;
		res.finished_task = fin_q ? fin_task_q : '0;
		res.completion_time = fin_q ? ct_q : '0;
		res.turnaround_time = fin_q ? tat_q : '0;
		res.waiting_time = fin_q ? wt_q : '0;
		res.response_time = fin_q ? rt_q : '0;
		res.all_done = ((nz_q & act_mask) == '0);
	end
endmodule

// ===== hw/rtl/round_robin_quantum_scheduler.sv =====
`timescale 1ns / 1ps
// a load goes straight to the output stage; a tick runs a 16-entry arrival scan,
// a preempt step and a dispatch step that discards stale queue entries
// throughput: one request at a time; the next is taken once the result is written to
// the output register
// reset: arst_n clears queue, flags, time and running task; quantum resets to 1
module round_robin_quantum_scheduler (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// operation
	input logic [0:0] s_axis_tuser,
	// task_index, arrival_time, burst_time, 4 zero bits
	input logic [39:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// running_valid, running_task, remaining_burst, dispatched, preempted,
	// finished_valid, finished_task, completion_time, turnaround_time,
	// waiting_time, response_time, all_done, 3 zero bits
	output logic [95:0] m_axis_tdata,
	input logic cfg_we,
	input logic [0:0] cfg_addr,
	input logic [7:0] cfg_wdata
);
	import rrqs_pkg::*;

	in_req_t req_q;
	in_req_t in_word;
	cmd_t cmd;
	sts_t sts;
	out_res_t res;
	logic busy, in_fire, out_free;
	logic [95:0] out_q;
	logic out_valid_q;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign in_word = {s_axis_tdata[35:0], s_axis_tuser};

	// request capture
	always_ff @(posedge clk) begin
		if (in_fire) req_q <= in_word;
	end

	rrqs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_is_tick(s_axis_tuser[0] == OP_TICK), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	in_req_t dp_req;
	assign dp_req = in_fire ? in_word : req_q;

	rrqs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(dp_req), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_sel(cfg_addr), .cfg_data(cfg_wdata),
		.sts(sts), .res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish_item) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish_item) out_q <= {3'b0, res};
	end
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	// result never overwritten while waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !cmd.finish_item)
		else $error("result overwritten");
	// no request taken in the cycle that finishes a result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_item |=> !$past(in_fire))
		else $error("overlap");
	// dispatch only while running
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_item |-> (!res.dispatched || res.running_valid))
		else $error("dispatch without task");
endmodule
